// ----- rtl/tcfsm_pkg.sv -----
`default_nettype none
package tcfsm_pkg;

  localparam logic [2:0] CMD_CONNECT  = 3'd0;
  localparam logic [2:0] CMD_SHUTDOWN = 3'd1;
  localparam logic [2:0] CMD_CLOSE    = 3'd2;
  localparam logic [2:0] CMD_SEGMENT  = 3'd3;
  localparam logic [2:0] CMD_TIMER    = 3'd4;
  localparam logic [2:0] CMD_RX_AFTER = 3'd5;

  localparam logic [2:0] TID_RETX      = 3'd0;
  localparam logic [2:0] TID_LAST_KILL = 3'd4;

  localparam logic [2:0] SK_NONE    = 3'd0;
  localparam logic [2:0] SK_SYN     = 3'd1;
  localparam logic [2:0] SK_SYN_ACK = 3'd2;
  localparam logic [2:0] SK_ACK     = 3'd3;
  localparam logic [2:0] SK_FIN     = 3'd4;
  localparam logic [2:0] SK_RST     = 3'd5;
  localparam logic [2:0] SK_RESEND  = 3'd6;

  localparam logic [1:0] TA_KEEP    = 2'd0;
  localparam logic [1:0] TA_STOP    = 2'd1;
  localparam logic [1:0] TA_RESTART = 2'd2;

  typedef enum logic [9:0] {
    ST_CLOSED       = 10'b00_0000_0001,
    ST_SYN_SENT     = 10'b00_0000_0010,
    ST_SYN_RCVD     = 10'b00_0000_0100,
    ST_ESTABLISHED  = 10'b00_0000_1000,
    ST_FIN_WAIT_1   = 10'b00_0001_0000,
    ST_FIN_WAIT_2   = 10'b00_0010_0000,
    ST_CLOSING      = 10'b00_0100_0000,
    ST_TIME_WAIT    = 10'b00_1000_0000,
    ST_CLOSE_WAIT   = 10'b01_0000_0000,
    ST_FIN_ACK_WAIT = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       seg_syn;
    logic       seg_ack;
    logic       seg_fin;
    logic       seg_rst;
    logic       window_empty;
    logic       fast_retransmit;
    logic [2:0] timer_id;
  } event_t;

  typedef struct packed {
    logic [2:0] send_kind;
    logic [1:0] retx_timer_action;
    logic [1:0] hs_timer_action;
    logic [1:0] fin_timer_action;
    logic       close_timer_start;
    logic       time_wait_start;
    logic       teardown;
    logic [3:0] conn_state;
    logic       cmd_error;
  } result_t;

  function automatic logic [3:0] phase_code(phase_t p);
    logic [3:0] c;
    c = 4'd0;
    unique case (p)
      ST_CLOSED:       c = 4'd0;
      ST_SYN_SENT:     c = 4'd1;
      ST_SYN_RCVD:     c = 4'd2;
      ST_ESTABLISHED:  c = 4'd3;
      ST_FIN_WAIT_1:   c = 4'd4;
      ST_FIN_WAIT_2:   c = 4'd5;
      ST_CLOSING:      c = 4'd6;
      ST_TIME_WAIT:    c = 4'd7;
      ST_CLOSE_WAIT:   c = 4'd8;
      ST_FIN_ACK_WAIT: c = 4'd9;
      default:         c = 4'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tcp_connection_fsm_top.sv -----
// Per-connection TCP state machine that takes one event item at a time.
// The input channel (in_valid/in_ready) carries one event: an application
// connect, shutdown or close, a received segment with its flags and the
// send-window status, a timer expiry, or data arriving after close.
// The result channel (out_valid/out_ready) returns exactly one item per
// event: the segment to send, timer actions, time-wait and close-timer
// starts, a teardown pulse, the state after the event and an error flag.
// An accepted item is held in the input register, is decoded against the
// connection state and lands in the result register, which offers it on
// out_valid. One item per cycle is sustained while out_ready stays high;
// the state update between the two registers is combinational and sets
// that figure. If the receiver stalls, the result register holds its item,
// the input register fills, and in_ready drops until out_ready returns.
// Reset empties both registers and returns the connection to CLOSED with
// the torn-down and application-closed flags cleared.
`default_nettype none
module tcp_connection_fsm_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [2:0] in_cmd,
  input  wire        in_seg_syn,
  input  wire        in_seg_ack,
  input  wire        in_seg_fin,
  input  wire        in_seg_rst,
  input  wire        in_window_empty,
  input  wire        in_fast_retransmit,
  input  wire  [2:0] in_timer_id,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_send_kind,
  output logic [1:0] out_retx_timer_action,
  output logic [1:0] out_hs_timer_action,
  output logic [1:0] out_fin_timer_action,
  output logic       out_close_timer_start,
  output logic       out_time_wait_start,
  output logic       out_teardown,
  output logic [3:0] out_conn_state,
  output logic       out_cmd_error
);
  import tcfsm_pkg::*;

  event_t  in_event;
  event_t  ev;
  logic    ev_valid;
  logic    res_ready;
  logic    go;
  result_t res;
  result_t out_res;

  assign in_event = {in_cmd, in_seg_syn, in_seg_ack, in_seg_fin, in_seg_rst,
                     in_window_empty, in_fast_retransmit, in_timer_id};

  assign go = ev_valid && res_ready;

  tcfsm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_event (in_event),
    .ev_valid (ev_valid),
    .ev_take  (go),
    .ev       (ev)
  );

  tcfsm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .ev    (ev),
    .res   (res)
  );

  tcfsm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (ev_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_send_kind         = out_res.send_kind;
  assign out_retx_timer_action = out_res.retx_timer_action;
  assign out_hs_timer_action   = out_res.hs_timer_action;
  assign out_fin_timer_action  = out_res.fin_timer_action;
  assign out_close_timer_start = out_res.close_timer_start;
  assign out_time_wait_start   = out_res.time_wait_start;
  assign out_teardown          = out_res.teardown;
  assign out_conn_state        = out_res.conn_state;
  assign out_cmd_error         = out_res.cmd_error;

endmodule
`default_nettype wire

// ----- rtl/tcfsm_in_stage.sv -----
`default_nettype none
module tcfsm_in_stage (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  tcfsm_pkg::event_t     in_event,
  output logic                  ev_valid,
  input  wire                   ev_take,
  output tcfsm_pkg::event_t     ev
);
  import tcfsm_pkg::*;

  logic   valid_r;
  event_t ev_r;

  assign in_ready = !valid_r || ev_take;
  assign ev_valid = valid_r;
  assign ev       = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r <= in_event;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tcfsm_core.sv -----
`default_nettype none
module tcfsm_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   go,
  input  tcfsm_pkg::event_t     ev,
  output tcfsm_pkg::result_t    res
);
  import tcfsm_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   torn_r, torn_nxt;
  logic   app_closed_r, app_closed_nxt;
  logic   closing;
  logic   down;

  assign closing = (phase_r == ST_FIN_WAIT_1) || (phase_r == ST_FIN_WAIT_2) ||
                   (phase_r == ST_TIME_WAIT) || (phase_r == ST_CLOSING) ||
                   (phase_r == ST_FIN_ACK_WAIT);

  always_comb begin
    phase_nxt      = phase_r;
    torn_nxt       = torn_r;
    app_closed_nxt = app_closed_r;
    res            = '0;
    down           = 1'b0;
    if (!torn_r) begin
      unique case (ev.cmd)
        CMD_CONNECT: begin
          if (phase_r != ST_CLOSED) begin
            res.cmd_error = 1'b1;
          end else begin
            phase_nxt             = ST_SYN_SENT;
            res.send_kind         = SK_SYN;
            res.retx_timer_action = TA_RESTART;
            res.hs_timer_action   = TA_RESTART;
          end
        end
        CMD_SHUTDOWN, CMD_CLOSE: begin
          if (!closing) begin
            if (phase_r == ST_ESTABLISHED || phase_r == ST_CLOSE_WAIT) begin
              phase_nxt = (phase_r == ST_ESTABLISHED) ? ST_FIN_WAIT_1 : ST_FIN_ACK_WAIT;
              res.send_kind         = SK_FIN;
              res.retx_timer_action = TA_RESTART;
              res.fin_timer_action  = TA_RESTART;
            end else begin
              res.cmd_error = 1'b1;
            end
          end
          if (ev.cmd == CMD_CLOSE) begin
            app_closed_nxt = 1'b1;
          end
        end
        CMD_SEGMENT: begin
          priority if (ev.seg_syn && !ev.seg_ack) begin
            if (!ev.window_empty) begin
              res.send_kind = SK_RESEND;
            end else begin
              res.send_kind         = SK_SYN_ACK;
              res.retx_timer_action = TA_RESTART;
              res.hs_timer_action   = TA_RESTART;
              phase_nxt             = ST_SYN_RCVD;
            end
          end else if (ev.seg_syn) begin
            if (phase_r == ST_SYN_SENT) begin
              res.hs_timer_action = TA_STOP;
              if (ev.window_empty) begin
                res.retx_timer_action = TA_STOP;
              end
              phase_nxt = ST_ESTABLISHED;
            end
            res.send_kind = SK_ACK;
          end else if (ev.seg_fin) begin
            if (phase_r == ST_ESTABLISHED) begin
              phase_nxt = ST_CLOSE_WAIT;
            end else if (phase_r == ST_FIN_WAIT_2) begin
              phase_nxt           = ST_TIME_WAIT;
              res.time_wait_start = 1'b1;
            end else if (phase_r == ST_FIN_WAIT_1) begin
              phase_nxt = ST_CLOSING;
            end
            res.send_kind = SK_ACK;
          end else if (ev.seg_ack) begin
            if (ev.fast_retransmit) begin
              res.send_kind = SK_RESEND;
            end
            res.retx_timer_action = ev.window_empty ? TA_STOP : TA_RESTART;
            priority if (phase_r == ST_SYN_RCVD) begin
              phase_nxt           = ST_ESTABLISHED;
              res.hs_timer_action = TA_STOP;
            end else if (phase_r == ST_FIN_WAIT_1 && ev.window_empty) begin
              phase_nxt            = ST_FIN_WAIT_2;
              res.fin_timer_action = TA_STOP;
            end else if (phase_r == ST_FIN_ACK_WAIT && ev.window_empty) begin
              phase_nxt            = ST_CLOSED;
              res.fin_timer_action = TA_STOP;
              down                 = 1'b1;
            end else if (phase_r == ST_CLOSING && ev.window_empty) begin
              phase_nxt           = ST_TIME_WAIT;
              res.time_wait_start = 1'b1;
            end else begin
            end
          end else if (ev.seg_rst) begin
            down = 1'b1;
          end else begin
            res.send_kind = SK_ACK;
          end
        end
        CMD_TIMER: begin
          if (ev.timer_id == TID_RETX) begin
            if (!ev.window_empty) begin
              res.send_kind = SK_RESEND;
            end
          end else if (ev.timer_id <= TID_LAST_KILL) begin
            down = 1'b1;
          end
        end
        CMD_RX_AFTER: begin
          if (app_closed_r) begin
            phase_nxt             = ST_CLOSED;
            res.close_timer_start = 1'b1;
            res.send_kind         = SK_RST;
          end
        end
        default: begin
        end
      endcase
      if (down) begin
        torn_nxt              = 1'b1;
        res.retx_timer_action = TA_STOP;
      end
    end
    res.teardown   = down;
    res.conn_state = phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ST_CLOSED;
      torn_r       <= 1'b0;
      app_closed_r <= 1'b0;
    end else if (go) begin
      phase_r      <= phase_nxt;
      torn_r       <= torn_nxt;
      app_closed_r <= app_closed_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tcfsm_out_stage.sv -----
`default_nettype none
module tcfsm_out_stage (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   res_valid,
  output logic                  res_ready,
  input  tcfsm_pkg::result_t    res,
  output logic                  out_valid,
  input  wire                   out_ready,
  output tcfsm_pkg::result_t    out_res
);
  import tcfsm_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tcp_connection_fsm_top_tb.sv -----
module tcp_connection_fsm_top_tb;
  import tcfsm_pkg::*;

  typedef enum logic [3:0] {
    C_CLOSED, C_SYN_SENT, C_SYN_RCVD, C_ESTABLISHED, C_FIN_WAIT_1,
    C_FIN_WAIT_2, C_CLOSING, C_TIME_WAIT, C_CLOSE_WAIT, C_FIN_ACK_WAIT
  } conn_e;

  typedef struct packed {
    event_t  ev;
    logic    fixed;
    result_t res;
  } stim_row_t;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [2:0] TID_SPARE_LO = 3'd5;
  localparam logic [2:0] TID_SPARE_HI = 3'd7;
  localparam result_t    NO_RES       = '0;
  localparam int         RANDOM_PER_PHASE = 420;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_cmd = '0;
  logic       in_seg_syn = 1'b0;
  logic       in_seg_ack = 1'b0;
  logic       in_seg_fin = 1'b0;
  logic       in_seg_rst = 1'b0;
  logic       in_window_empty = 1'b0;
  logic       in_fast_retransmit = 1'b0;
  logic [2:0] in_timer_id = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_send_kind;
  logic [1:0] out_retx_timer_action;
  logic [1:0] out_hs_timer_action;
  logic [1:0] out_fin_timer_action;
  logic       out_close_timer_start;
  logic       out_time_wait_start;
  logic       out_teardown;
  logic [3:0] out_conn_state;
  logic       out_cmd_error;

  conn_e     conn_phase = C_CLOSED;
  bit        conn_torn = 1'b0;
  bit        app_closed_seen = 1'b0;
  result_t   pending_responses[$];
  stim_row_t stim_rows[$];
  logic      row_fixed = 1'b0;
  result_t   row_res = '0;
  int        snd_idle = 0;
  int        rcv_idle = 0;
  int        n_events = 0;
  int        n_responses = 0;
  int        n_errors = 0;

  tcp_connection_fsm_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_cmd                (in_cmd),
    .in_seg_syn            (in_seg_syn),
    .in_seg_ack            (in_seg_ack),
    .in_seg_fin            (in_seg_fin),
    .in_seg_rst            (in_seg_rst),
    .in_window_empty       (in_window_empty),
    .in_fast_retransmit    (in_fast_retransmit),
    .in_timer_id           (in_timer_id),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_send_kind         (out_send_kind),
    .out_retx_timer_action (out_retx_timer_action),
    .out_hs_timer_action   (out_hs_timer_action),
    .out_fin_timer_action  (out_fin_timer_action),
    .out_close_timer_start (out_close_timer_start),
    .out_time_wait_start   (out_time_wait_start),
    .out_teardown          (out_teardown),
    .out_conn_state        (out_conn_state),
    .out_cmd_error         (out_cmd_error)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  function automatic event_t make_event(input logic [2:0] cmd, input logic s, input logic a,
                                        input logic f, input logic r, input logic we,
                                        input logic fr, input logic [2:0] tid);
    event_t e;
    e.cmd = cmd;
    e.seg_syn = s;
    e.seg_ack = a;
    e.seg_fin = f;
    e.seg_rst = r;
    e.window_empty = we;
    e.fast_retransmit = fr;
    e.timer_id = tid;
    return e;
  endfunction

  function automatic result_t make_result(input logic [2:0] send, input logic [1:0] retx,
                                          input logic [1:0] hs, input logic [1:0] fint,
                                          input logic cls, input logic tw, input logic dn,
                                          input conn_e st, input logic err);
    result_t r;
    r.send_kind = send;
    r.retx_timer_action = retx;
    r.hs_timer_action = hs;
    r.fin_timer_action = fint;
    r.close_timer_start = cls;
    r.time_wait_start = tw;
    r.teardown = dn;
    r.conn_state = st;
    r.cmd_error = err;
    return r;
  endfunction

  // Advances the connection state by one event and returns the response it causes.
  function automatic result_t expected_response(input event_t ev);
    result_t r;
    r = '0;
    if (!conn_torn) begin
      case (ev.cmd)
        CMD_CONNECT: begin
          if (conn_phase != C_CLOSED) begin
            r.cmd_error = 1'b1;
          end else begin
            conn_phase = C_SYN_SENT;
            r.send_kind = SK_SYN;
            r.retx_timer_action = TA_RESTART;
            r.hs_timer_action = TA_RESTART;
          end
        end
        CMD_SHUTDOWN, CMD_CLOSE: begin
          if (conn_phase == C_ESTABLISHED || conn_phase == C_CLOSE_WAIT) begin
            if (conn_phase == C_ESTABLISHED) begin
              conn_phase = C_FIN_WAIT_1;
            end else begin
              conn_phase = C_FIN_ACK_WAIT;
            end
            r.send_kind = SK_FIN;
            r.retx_timer_action = TA_RESTART;
            r.fin_timer_action = TA_RESTART;
          end else if (!(conn_phase == C_FIN_WAIT_1 || conn_phase == C_FIN_WAIT_2 ||
                         conn_phase == C_CLOSING || conn_phase == C_TIME_WAIT ||
                         conn_phase == C_FIN_ACK_WAIT)) begin
            r.cmd_error = 1'b1;
          end
          if (ev.cmd == CMD_CLOSE) begin
            app_closed_seen = 1'b1;
          end
        end
        CMD_SEGMENT: begin
          if (ev.seg_syn && !ev.seg_ack) begin
            if (!ev.window_empty) begin
              r.send_kind = SK_RESEND;
            end else begin
              r.send_kind = SK_SYN_ACK;
              r.retx_timer_action = TA_RESTART;
              r.hs_timer_action = TA_RESTART;
              conn_phase = C_SYN_RCVD;
            end
          end else if (ev.seg_syn) begin
            if (conn_phase == C_SYN_SENT) begin
              r.hs_timer_action = TA_STOP;
              if (ev.window_empty) begin
                r.retx_timer_action = TA_STOP;
              end
              conn_phase = C_ESTABLISHED;
            end
            r.send_kind = SK_ACK;
          end else if (ev.seg_fin) begin
            if (conn_phase == C_ESTABLISHED) begin
              conn_phase = C_CLOSE_WAIT;
            end else if (conn_phase == C_FIN_WAIT_2) begin
              conn_phase = C_TIME_WAIT;
              r.time_wait_start = 1'b1;
            end else if (conn_phase == C_FIN_WAIT_1) begin
              conn_phase = C_CLOSING;
            end
            r.send_kind = SK_ACK;
          end else if (ev.seg_ack) begin
            if (ev.fast_retransmit) begin
              r.send_kind = SK_RESEND;
            end
            r.retx_timer_action = ev.window_empty ? TA_STOP : TA_RESTART;
            if (conn_phase == C_SYN_RCVD) begin
              conn_phase = C_ESTABLISHED;
              r.hs_timer_action = TA_STOP;
            end else if (conn_phase == C_FIN_WAIT_1 && ev.window_empty) begin
              conn_phase = C_FIN_WAIT_2;
              r.fin_timer_action = TA_STOP;
            end else if (conn_phase == C_FIN_ACK_WAIT && ev.window_empty) begin
              conn_phase = C_CLOSED;
              r.fin_timer_action = TA_STOP;
              r.teardown = 1'b1;
            end else if (conn_phase == C_CLOSING && ev.window_empty) begin
              conn_phase = C_TIME_WAIT;
              r.time_wait_start = 1'b1;
            end
          end else if (ev.seg_rst) begin
            r.teardown = 1'b1;
          end else begin
            r.send_kind = SK_ACK;
          end
        end
        CMD_TIMER: begin
          if (ev.timer_id == TID_RETX) begin
            if (!ev.window_empty) begin
              r.send_kind = SK_RESEND;
            end
          end else if (ev.timer_id <= TID_LAST_KILL) begin
            r.teardown = 1'b1;
          end
        end
        CMD_RX_AFTER: begin
          if (app_closed_seen) begin
            conn_phase = C_CLOSED;
            r.close_timer_start = 1'b1;
            r.send_kind = SK_RST;
          end
        end
        default: begin
        end
      endcase
      if (r.teardown) begin
        conn_torn = 1'b1;
        r.retx_timer_action = TA_STOP;
      end
    end
    r.conn_state = conn_phase;
    return r;
  endfunction

  function automatic bit kills_connection(input event_t ev);
    if (ev.cmd == CMD_TIMER) begin
      return ev.timer_id != TID_RETX && ev.timer_id <= TID_LAST_KILL;
    end
    if (ev.cmd != CMD_SEGMENT || ev.seg_syn || ev.seg_fin) begin
      return 1'b0;
    end
    if (ev.seg_ack) begin
      return conn_phase == C_FIN_ACK_WAIT && ev.window_empty;
    end
    return ev.seg_rst;
  endfunction

  function automatic event_t as_segment(input event_t e, input logic s, input logic a,
                                        input logic f);
    e.cmd = CMD_SEGMENT;
    e.seg_syn = s;
    e.seg_ack = a;
    e.seg_fin = f;
    if (!s && !a && !f) begin
      e.seg_rst = 1'b0;
    end
    return e;
  endfunction

  // Mostly events that move the connection along its normal lifecycle, the rest noise.
  // Nothing drawn here may tear the connection down.
  task automatic pick_event(output event_t ev);
    logic [13:0] raw;
    int k;
    do begin
      raw = 14'($urandom);
      ev = raw;
      k = $urandom_range(0, 4);
      if ($urandom_range(0, 99) < 70) begin
        case (conn_phase)
          C_CLOSED: begin
            if (k < 3) begin
              ev.cmd = CMD_CONNECT;
            end else begin
              ev = as_segment(ev, 1'b1, 1'b0, 1'b0);
              ev.window_empty = 1'b1;
            end
          end
          C_SYN_SENT, C_SYN_RCVD: begin
            if (k < 4) begin
              ev = as_segment(ev, conn_phase == C_SYN_SENT, 1'b1, 1'b0);
            end else begin
              ev.cmd = CMD_TIMER;
              ev.timer_id = TID_RETX;
            end
          end
          C_ESTABLISHED: begin
            case (k)
              0: ev = as_segment(ev, 1'b0, 1'b0, 1'b0);
              1: ev = as_segment(ev, 1'b0, 1'b1, 1'b0);
              2: ev.cmd = CMD_SHUTDOWN;
              3: ev.cmd = CMD_CLOSE;
              default: ev = as_segment(ev, 1'b0, ev.seg_ack, 1'b1);
            endcase
          end
          C_FIN_WAIT_1: begin
            if (k < 3) begin
              ev = as_segment(ev, 1'b0, 1'b1, 1'b0);
              if (k < 2) begin
                ev.window_empty = 1'b1;
              end
            end else begin
              ev = as_segment(ev, 1'b0, ev.seg_ack, 1'b1);
            end
          end
          C_FIN_WAIT_2: begin
            ev = as_segment(ev, 1'b0, ev.seg_ack, k < 3);
          end
          C_CLOSING: begin
            ev = as_segment(ev, 1'b0, 1'b1, 1'b0);
          end
          C_TIME_WAIT, C_CLOSE_WAIT, C_FIN_ACK_WAIT: begin
            if (k < 2) begin
              if (conn_phase == C_TIME_WAIT) begin
                ev.cmd = CMD_CLOSE;
              end else if (conn_phase == C_CLOSE_WAIT) begin
                ev.cmd = k[0] ? CMD_CLOSE : CMD_SHUTDOWN;
              end else begin
                ev = as_segment(ev, 1'b0, 1'b1, 1'b0);
                ev.window_empty = 1'b0;
              end
            end else if (k < 4) begin
              ev.cmd = CMD_RX_AFTER;
            end else begin
              ev = as_segment(ev, 1'b1, 1'b0, 1'b0);
              ev.window_empty = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end while (kills_connection(ev));
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_event(input event_t ev, input logic fixed, input result_t res);
    int seen;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= ev.cmd;
    in_seg_syn <= ev.seg_syn;
    in_seg_ack <= ev.seg_ack;
    in_seg_fin <= ev.seg_fin;
    in_seg_rst <= ev.seg_rst;
    in_window_empty <= ev.window_empty;
    in_fast_retransmit <= ev.fast_retransmit;
    in_timer_id <= ev.timer_id;
    row_fixed = fixed;
    row_res = res;
    seen = n_events;
    do @(negedge clk); while (n_events == seen);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
               $time, name, n_responses, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    event_t  ev;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          n_errors++;
          $display("%0t: result with no event outstanding, state %0d", $time, out_conn_state);
        end else begin
          want = pending_responses.pop_front();
          check_field("send_kind", 4'(want.send_kind), 4'(out_send_kind));
          check_field("retx_timer_action", 4'(want.retx_timer_action),
                      4'(out_retx_timer_action));
          check_field("hs_timer_action", 4'(want.hs_timer_action), 4'(out_hs_timer_action));
          check_field("fin_timer_action", 4'(want.fin_timer_action),
                      4'(out_fin_timer_action));
          check_field("close_timer_start", 4'(want.close_timer_start),
                      4'(out_close_timer_start));
          check_field("time_wait_start", 4'(want.time_wait_start), 4'(out_time_wait_start));
          check_field("teardown", 4'(want.teardown), 4'(out_teardown));
          check_field("conn_state", want.conn_state, out_conn_state);
          check_field("cmd_error", 4'(want.cmd_error), 4'(out_cmd_error));
        end
        n_responses++;
      end
      if (in_valid && in_ready) begin
        ev = {in_cmd, in_seg_syn, in_seg_ack, in_seg_fin, in_seg_rst, in_window_empty,
              in_fast_retransmit, in_timer_id};
        want = expected_response(ev);
        if (row_fixed) begin
          want = row_res;
        end
        pending_responses.push_back(want);
        n_events++;
      end
    end
  end

  initial begin
    #2000000;
    $display("tcp_connection_fsm_top_tb failed");
    $finish;
  end

  initial begin
    event_t      ev;
    logic [13:0] raw;
    int          cause;
    string       cause_name;

    // Directed lifecycle walk, including both the active and the passive open.
    stim_rows.push_back({make_event(CMD_SHUTDOWN, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b1,
        make_result(SK_NONE, TA_KEEP, TA_KEEP, TA_KEEP, 0, 0, 0, C_CLOSED, 1)});
    stim_rows.push_back({make_event(CMD_CONNECT, 0, 0, 0, 0, 1, 0, TID_RETX), 1'b1,
        make_result(SK_SYN, TA_RESTART, TA_RESTART, TA_KEEP, 0, 0, 0, C_SYN_SENT, 0)});
    stim_rows.push_back({make_event(CMD_CONNECT, 1, 1, 1, 1, 1, 1, TID_SPARE_HI), 1'b1,
        make_result(SK_NONE, TA_KEEP, TA_KEEP, TA_KEEP, 0, 0, 0, C_SYN_SENT, 1)});
    stim_rows.push_back({make_event(CMD_RX_AFTER, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_TIMER, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_TIMER, 0, 0, 0, 0, 1, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 1, 1, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 1, 0, 0, 0, 1, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 1, 0, 1, 1, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 1, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 1, 0, 1, 1, 1, 1, TID_SPARE_HI), 1'b0,
        NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 1, 0, 0, 1, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SHUTDOWN, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b1,
        make_result(SK_FIN, TA_RESTART, TA_KEEP, TA_RESTART, 0, 0, 0, C_FIN_WAIT_1, 0)});
    stim_rows.push_back({make_event(CMD_SHUTDOWN, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 1, 1, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 1, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 1, 0, 0, 1, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 0, 1, 0, 1, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_CLOSE, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_RX_AFTER, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b1,
        make_result(SK_RST, TA_KEEP, TA_KEEP, TA_KEEP, 1, 0, 0, C_CLOSED, 0)});
    stim_rows.push_back({make_event(CMD_SPARE_HI, 1, 1, 1, 1, 1, 1, TID_SPARE_HI), 1'b1,
        make_result(SK_NONE, TA_KEEP, TA_KEEP, TA_KEEP, 0, 0, 0, C_CLOSED, 0)});
    stim_rows.push_back({make_event(CMD_TIMER, 0, 0, 0, 0, 0, 0, TID_SPARE_HI), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_CONNECT, 0, 0, 0, 0, 0, 0, TID_SPARE_LO), 1'b0,
        NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 1, 1, 0, 0, 1, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 0, 1, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_CLOSE, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES});
    stim_rows.push_back({make_event(CMD_SEGMENT, 0, 1, 0, 0, 0, 1, TID_RETX), 1'b0, NO_RES});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    snd_idle = 36;
    rcv_idle = 86;
    foreach (stim_rows[i]) begin
      push_event(stim_rows[i].ev, stim_rows[i].fixed, stim_rows[i].res);
    end

    for (int p = 0; p < 3; p++) begin
      snd_idle = (p == 0) ? 36 : (p == 1) ? 86 : 0;
      rcv_idle = (p == 0) ? 86 : (p == 1) ? 36 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick_event(ev);
        push_event(ev, 1'b0, NO_RES);
      end
      wait_drained();
    end

    // Only one teardown is possible per run, so its cause is left to the seed.
    cause = $urandom_range(0, 2);
    raw = 14'($urandom);
    if (cause == 0) begin
      cause_name = "a bare RST segment";
      push_event(make_event(CMD_SEGMENT, 0, 0, 0, 1, raw[0], raw[1], raw[4:2]), 1'b0, NO_RES);
    end else if (cause == 1) begin
      cause_name = "a timer expiry";
      push_event(make_event(CMD_TIMER, raw[0], raw[1], raw[2], raw[3], raw[4], raw[5],
                            3'($urandom_range(TID_RETX + 1, TID_LAST_KILL))), 1'b0, NO_RES);
    end else begin
      cause_name = "the final ACK of a passive close";
      push_event(make_event(CMD_SEGMENT, 1, 0, 0, 0, 1, 0, TID_RETX), 1'b0, NO_RES);
      push_event(make_event(CMD_SEGMENT, 0, 1, 0, 0, 1, 0, TID_RETX), 1'b0, NO_RES);
      push_event(make_event(CMD_SEGMENT, 0, 0, 1, 0, 0, 0, TID_RETX), 1'b0, NO_RES);
      push_event(make_event(CMD_SHUTDOWN, 0, 0, 0, 0, 0, 0, TID_RETX), 1'b0, NO_RES);
      push_event(make_event(CMD_SEGMENT, 0, 1, 0, 0, 1, raw[0], TID_RETX), 1'b0, NO_RES);
    end
    for (int c = 0; c < 8; c++) begin
      raw = 14'($urandom);
      ev = raw;
      ev.cmd = 3'(c);
      push_event(ev, 1'b0, NO_RES);
    end

    wait_drained();
    repeat (4) @(negedge clk);

    $display("Checked %0d responses to %0d events over three handshake stall mixes.",
             n_responses, n_events);
    $display("The connection was torn down by %s and then fed every event code.", cause_name);
    if (n_errors == 0) begin
      $display("tcp_connection_fsm_top_tb passed");
    end else begin
      $display("tcp_connection_fsm_top_tb failed");
    end
    $finish;
  end

endmodule
